### rtl/core/ready_bitmap_priority_finder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ready bitmap priority finder
// Clocked on clk and disabled while rst is high; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef READY_BITMAP_PRIORITY_FINDER_ASSERT_SVH
`define READY_BITMAP_PRIORITY_FINDER_ASSERT_SVH

`ifndef SYNTHESIS

`define RBPF_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rbpf assertion failed");

`define RBPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbpf assertion failed");

`else

`define RBPF_ASSERT(lbl, cond)

`define RBPF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/core/rbpf_pkg.sv
// ----------------------------------------------------------------------------
// Ready bitmap priority finder package
// Shared widths, codes, the queue item type and the 16-bit priority encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbpf_pkg;

  localparam int PRIO_W        = 8;
  localparam int COUNT_W       = 6;
  localparam int GROUP_W       = 4;
  localparam int GROUPS        = 16;
  localparam int LEVEL_COUNT   = 256;
  localparam int MAX_PER_LEVEL = 32;

  localparam logic ACT_PUSH   = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef struct packed {
    logic              action;
    logic [PRIO_W-1:0] prio;
    logic              out_of_range;
  } rbpf_item_t;

  function automatic logic [GROUP_W-1:0] top_bit16(input logic [GROUPS-1:0] v);
    logic [GROUP_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < GROUPS; i++) begin
      if (v[i]) begin
        pos = GROUP_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

### rtl/core/rbpf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/rbpf_front.sv
// ----------------------------------------------------------------------------
// Ready bitmap priority finder front end
// Accepts events, flags levels out of range and queues them two deep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbpf_front #(
  parameter int LEVEL_COUNT = rbpf_pkg::LEVEL_COUNT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic                         action,
  input  logic [rbpf_pkg::PRIO_W-1:0]  priority_req,
  output logic                         q_valid,
  output rbpf_pkg::rbpf_item_t         q_item,
  input  logic                         q_pop
);

  rbpf_pkg::rbpf_item_t slots [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           fill;
  logic                 push_fire;
  logic                 pop_fire;
  rbpf_pkg::rbpf_item_t item_in;

  assign req_stall = (fill == 2'd2);
  assign push_fire = req_valid && !req_stall;
  assign pop_fire  = q_pop && q_valid;
  assign q_valid   = (fill != 2'd0);
  assign q_item    = slots[rd_ptr];

  always_comb begin
    item_in.action       = action;
    item_in.prio         = priority_req;
    item_in.out_of_range = ({1'b0, priority_req} >= (rbpf_pkg::PRIO_W + 1)'(LEVEL_COUNT));
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push_fire) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop_fire) begin
        rd_ptr <= !rd_ptr;
      end
      if (push_fire && !pop_fire) begin
        fill <= fill + 2'd1;
      end else if (pop_fire && !push_fire) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

### rtl/core/rbpf_back.sv
// ----------------------------------------------------------------------------
// Ready bitmap priority finder back end
// Reads the level count, updates count and bitmaps, encodes the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbpf_back #(
  parameter int LEVEL_COUNT   = rbpf_pkg::LEVEL_COUNT,
  parameter int MAX_PER_LEVEL = rbpf_pkg::MAX_PER_LEVEL
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  rbpf_pkg::rbpf_item_t         q_item,
  output logic                         q_pop,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [rbpf_pkg::PRIO_W-1:0]  highest_level,
  output logic                         any_ready,
  output logic                         event_error
);

  `include "ready_bitmap_priority_finder_assert.svh"

  localparam int AW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t                              state;
  state_t                              state_next;
  rbpf_pkg::rbpf_item_t                cur;
  logic [rbpf_pkg::GROUPS-1:0]         level_masks [rbpf_pkg::GROUPS];
  logic [rbpf_pkg::GROUPS-1:0]         level_masks_next [rbpf_pkg::GROUPS];
  logic [rbpf_pkg::GROUPS-1:0]         group_mask;
  logic [rbpf_pkg::GROUPS-1:0]         group_mask_next;
  logic [rbpf_pkg::COUNT_W-1:0]        rdata;
  logic [rbpf_pkg::COUNT_W-1:0]        cnt;
  logic [rbpf_pkg::COUNT_W-1:0]        cnt_next;
  logic [rbpf_pkg::GROUP_W-1:0]        grp;
  logic [rbpf_pkg::GROUP_W-1:0]        bitp;
  logic [rbpf_pkg::GROUP_W-1:0]        top_g;
  logic [rbpf_pkg::GROUP_W-1:0]        top_l;
  logic                                occupied;
  logic                                err;
  logic                                upd_fire;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign upd_fire = (state == S_UPDATE) && (!rsp_valid || !rsp_stall);

  assign grp      = cur.prio[rbpf_pkg::PRIO_W-1:rbpf_pkg::GROUP_W];
  assign bitp     = cur.prio[rbpf_pkg::GROUP_W-1:0];
  assign occupied = level_masks[grp][bitp];
  assign cnt      = occupied ? rdata : '0;

  rbpf_ram #(
    .WIDTH (rbpf_pkg::COUNT_W),
    .DEPTH (LEVEL_COUNT)
  ) u_count_ram (
    .clk   (clk),
    .we    (upd_fire && !err),
    .waddr (cur.prio[AW-1:0]),
    .wdata (cnt_next),
    .re    (q_pop),
    .raddr (q_item.prio[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    err = cur.out_of_range;
    if (cur.action == rbpf_pkg::ACT_PUSH) begin
      if (cnt >= rbpf_pkg::COUNT_W'(MAX_PER_LEVEL)) begin
        err = 1'b1;
      end
      cnt_next = cnt + 1'b1;
    end else begin
      if (cnt == '0) begin
        err = 1'b1;
      end
      cnt_next = cnt - 1'b1;
    end
  end

  always_comb begin
    for (int g = 0; g < rbpf_pkg::GROUPS; g++) begin
      level_masks_next[g] = level_masks[g];
    end
    if (!err) begin
      if (cur.action == rbpf_pkg::ACT_PUSH && cnt == '0) begin
        level_masks_next[grp][bitp] = 1'b1;
      end else if (cur.action == rbpf_pkg::ACT_REMOVE && cnt == rbpf_pkg::COUNT_W'(1)) begin
        level_masks_next[grp][bitp] = 1'b0;
      end
    end
    for (int g = 0; g < rbpf_pkg::GROUPS; g++) begin
      group_mask_next[g] = |level_masks_next[g];
    end
    top_g = rbpf_pkg::top_bit16(group_mask_next);
    top_l = rbpf_pkg::top_bit16(level_masks_next[top_g]);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (upd_fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (upd_fire) begin
      highest_level <= {top_g, top_l};
      any_ready     <= |group_mask_next;
      event_error   <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      group_mask <= '0;
      for (int g = 0; g < rbpf_pkg::GROUPS; g++) begin
        level_masks[g] <= '0;
      end
    end else begin
      state <= state_next;
      if (upd_fire) begin
        rsp_valid  <= 1'b1;
        group_mask <= group_mask_next;
        for (int g = 0; g < rbpf_pkg::GROUPS; g++) begin
          level_masks[g] <= level_masks_next[g];
        end
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `RBPF_ASSERT_NEXT(a_update_holds, (state == S_UPDATE) && rsp_valid && rsp_stall, state == S_UPDATE)
  `RBPF_ASSERT(a_rsp_from_update, $rose(rsp_valid) |-> $past(state == S_UPDATE))
  `RBPF_ASSERT_NEXT(a_push_sets_group, upd_fire && !err && (cur.action == rbpf_pkg::ACT_PUSH), group_mask[$past(grp)] && level_masks[$past(grp)][$past(bitp)])
  `RBPF_ASSERT(a_idle_level_zero, (rsp_valid && !any_ready) |-> (highest_level == '0))

endmodule

### rtl/core/ready_bitmap_priority_finder.sv
// ----------------------------------------------------------------------------
// Ready bitmap priority finder
// Tracks ready threads per priority level and reports the top ready level.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  req      req_valid/req_stall   action, priority_req
//  rsp      rsp_valid/rsp_stall   highest_level, any_ready, event_error
//
// In the back end each item first has its count read from the count RAM,
// then the count write, bitmap update and two-level priority encode follow.
// A two-entry queue sits in front and the back end holds one more item, so up
// to three items are taken while a result is stalled.
// The level bitmap bits act as valid bits for the count RAM, so reset needs
// no clearing pass and the block accepts items right after reset.
// A stalled result holds the back end; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ready_bitmap_priority_finder #(
  parameter int LEVEL_COUNT   = rbpf_pkg::LEVEL_COUNT,
  parameter int MAX_PER_LEVEL = rbpf_pkg::MAX_PER_LEVEL
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic                         action,
  input  logic [rbpf_pkg::PRIO_W-1:0]  priority_req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [rbpf_pkg::PRIO_W-1:0]  highest_level,
  output logic                         any_ready,
  output logic                         event_error
);

  logic                 q_valid;
  logic                 q_pop;
  rbpf_pkg::rbpf_item_t q_item;

  rbpf_front #(
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .action       (action),
    .priority_req (priority_req),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  rbpf_back #(
    .LEVEL_COUNT   (LEVEL_COUNT),
    .MAX_PER_LEVEL (MAX_PER_LEVEL)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .highest_level (highest_level),
    .any_ready     (any_ready),
    .event_error   (event_error)
  );

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the ready bitmap priority finder
// Request items are pushed through a valid/stall driver and every response
// is checked against a cycle-free model of the per-level counts and the
// two-level ready bitmap. Directed events cover the empty, single-level and
// boundary levels. The random traffic fills levels to saturation, drains them
// and drains the whole ready set, under changing idle patterns on both
// channels and one long response hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 575;
  localparam int TAIL_CYCLES    = 20;
  localparam int HOT_LEVELS     = 6;

  localparam int PH_DIRECTED = 0;
  localparam int PH_RX_HEAVY = 1;
  localparam int PH_TX_HEAVY = 2;
  localparam int PH_FREE     = 3;

  typedef struct {
    logic                        act;
    logic [rbpf_pkg::PRIO_W-1:0] prio;
    int                          phase;
  } sched_event_t;

  typedef struct {
    logic [rbpf_pkg::PRIO_W-1:0] level;
    logic                        ready;
    logic                        err;
  } level_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_stall;
  logic                        action = rbpf_pkg::ACT_PUSH;
  logic [rbpf_pkg::PRIO_W-1:0] priority_req = '0;
  logic                        rsp_valid;
  logic                        rsp_stall = 1'b0;
  logic [rbpf_pkg::PRIO_W-1:0] highest_level;
  logic                        any_ready;
  logic                        event_error;

  sched_event_t  pending_events[$];
  level_result_t expected_levels[$];

  int queued_count [rbpf_pkg::LEVEL_COUNT];

  logic [rbpf_pkg::COUNT_W-1:0] ready_count [rbpf_pkg::LEVEL_COUNT];
  logic [15:0]                  level_bits [rbpf_pkg::GROUPS];
  logic [15:0]                  group_bits;

  int events_accepted = 0;
  int error_count     = 0;
  int stim_phase      = PH_DIRECTED;
  int hold_left       = 0;
  bit hold_done       = 1'b0;
  int quiet_cycles    = 0;

  ready_bitmap_priority_finder DUT (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .action        (action),
    .priority_req  (priority_req),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .highest_level (highest_level),
    .any_ready     (any_ready),
    .event_error   (event_error)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int sender_idle_pct(input int phase);
    case (phase)
      PH_RX_HEAVY: return 11;
      PH_TX_HEAVY: return 81;
      default:     return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct(input int phase);
    case (phase)
      PH_RX_HEAVY: return 81;
      PH_TX_HEAVY: return 11;
      default:     return 0;
    endcase
  endfunction

  function automatic logic [3:0] msb_index(input logic [15:0] bits);
    logic [3:0] idx;
    idx = '0;
    for (int i = 15; i >= 0; i--) begin
      if (bits[i]) begin
        idx = 4'(i);
        break;
      end
    end
    return idx;
  endfunction

  task automatic queue_event(input logic act, input logic [rbpf_pkg::PRIO_W-1:0] prio,
                             input int phase);
    sched_event_t ev;
    ev.act   = act;
    ev.prio  = prio;
    ev.phase = phase;
    pending_events.push_back(ev);
    if (act == rbpf_pkg::ACT_PUSH) begin
      if (queued_count[prio] < rbpf_pkg::MAX_PER_LEVEL) begin
        queued_count[prio]++;
      end
    end else if (queued_count[prio] != 0) begin
      queued_count[prio]--;
    end
  endtask

  task automatic apply_event(input logic act, input logic [rbpf_pkg::PRIO_W-1:0] prio);
    level_result_t res;
    logic [3:0]    grp;
    logic [3:0]    pos;
    logic [3:0]    top_grp;
    grp     = prio[7:4];
    pos     = prio[3:0];
    res.err = 1'b0;
    if (int'(prio) >= rbpf_pkg::LEVEL_COUNT) begin
      res.err = 1'b1;
    end else if (act == rbpf_pkg::ACT_PUSH) begin
      if (ready_count[prio] >= rbpf_pkg::MAX_PER_LEVEL) begin
        res.err = 1'b1;
      end else begin
        if (ready_count[prio] == 0) begin
          group_bits[grp]      = 1'b1;
          level_bits[grp][pos] = 1'b1;
        end
        ready_count[prio] = ready_count[prio] + 1'b1;
      end
    end else begin
      if (ready_count[prio] == 0) begin
        res.err = 1'b1;
      end else begin
        ready_count[prio] = ready_count[prio] - 1'b1;
        if (ready_count[prio] == 0) begin
          level_bits[grp][pos] = 1'b0;
          if (level_bits[grp] == 16'h0000) begin
            group_bits[grp] = 1'b0;
          end
        end
      end
    end
    top_grp   = msb_index(group_bits);
    res.level = {top_grp, msb_index(level_bits[top_grp])};
    res.ready = |group_bits;
    expected_levels.push_back(res);
  endtask

  always @(posedge clk) begin
    sched_event_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
      foreach (ready_count[i]) ready_count[i] = '0;
      foreach (level_bits[i]) level_bits[i] = '0;
      group_bits = '0;
    end else begin
      if (req_valid && !req_stall) begin
        apply_event(action, priority_req);
        events_accepted <= events_accepted + 1;
      end
      if (!req_valid || !req_stall) begin
        if (pending_events.size() != 0 &&
            $urandom_range(0, 99) >= sender_idle_pct(pending_events[0].phase)) begin
          nxt = pending_events.pop_front();
          action       <= nxt.act;
          priority_req <= nxt.prio;
          stim_phase   <= nxt.phase;
          req_valid    <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    level_result_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_levels.size() == 0) begin
          $error("unexpected response: highest_level %0d any_ready %0b event_error %0b",
                 highest_level, any_ready, event_error);
          error_count++;
        end else begin
          want = expected_levels.pop_front();
          if (highest_level !== want.level) begin
            $error("highest_level: expected %0d, actual %0d", want.level, highest_level);
            error_count++;
          end
          if (any_ready !== want.ready) begin
            $error("any_ready: expected %0b, actual %0b", want.ready, any_ready);
            error_count++;
          end
          if (event_error !== want.err) begin
            $error("event_error: expected %0b, actual %0b", want.err, event_error);
            error_count++;
          end
        end
      end
      if (hold_left != 0) begin
        rsp_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && stim_phase == PH_FREE && rsp_valid) begin
        rsp_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct(stim_phase));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int total;
    int lvl;
    int pick;
    int phase_start;
    bit first;
    int hot [HOT_LEVELS];

    foreach (queued_count[i]) queued_count[i] = 0;

    // Empty set, single levels at both ends, group boundaries, drain to empty.
    queue_event(rbpf_pkg::ACT_REMOVE, 8'd0,   PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_REMOVE, 8'd255, PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_PUSH,   8'd0,   PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_PUSH,   8'd255, PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_PUSH,   8'd255, PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_PUSH,   8'd16,  PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_PUSH,   8'd15,  PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_REMOVE, 8'd255, PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_REMOVE, 8'd255, PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_REMOVE, 8'd255, PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_PUSH,   8'd170, PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_PUSH,   8'd85,  PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_REMOVE, 8'd170, PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_REMOVE, 8'd16,  PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_REMOVE, 8'd85,  PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_REMOVE, 8'd15,  PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_REMOVE, 8'd0,   PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_REMOVE, 8'd0,   PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_PUSH,   8'd240, PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_PUSH,   8'd1,   PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_REMOVE, 8'd240, PH_DIRECTED);
    queue_event(rbpf_pkg::ACT_REMOVE, 8'd1,   PH_DIRECTED);

    // Each phase opens with a level filled past saturation and drained past
    // empty, then mixes more of those, full drains of the ready set and
    // bursts of events on a few hot levels.
    for (int ph = PH_RX_HEAVY; ph <= PH_FREE; ph++) begin
      phase_start = pending_events.size();
      first = 1'b1;
      while (pending_events.size() - phase_start < PHASE_ITEMS) begin
        pick  = first ? 0 : $urandom_range(0, 9);
        first = 1'b0;
        if (pick == 0) begin
          lvl = $urandom_range(0, rbpf_pkg::LEVEL_COUNT - 1);
          while (queued_count[lvl] < rbpf_pkg::MAX_PER_LEVEL) begin
            queue_event(rbpf_pkg::ACT_PUSH, (rbpf_pkg::PRIO_W)'(lvl), ph);
          end
          queue_event(rbpf_pkg::ACT_PUSH, (rbpf_pkg::PRIO_W)'(lvl), ph);
          while (queued_count[lvl] != 0) begin
            queue_event(rbpf_pkg::ACT_REMOVE, (rbpf_pkg::PRIO_W)'(lvl), ph);
          end
          queue_event(rbpf_pkg::ACT_REMOVE, (rbpf_pkg::PRIO_W)'(lvl), ph);
        end else if (pick == 1) begin
          for (int l = rbpf_pkg::LEVEL_COUNT - 1; l >= 0; l--) begin
            while (queued_count[l] != 0) begin
              queue_event(rbpf_pkg::ACT_REMOVE, (rbpf_pkg::PRIO_W)'(l), ph);
            end
          end
        end else begin
          foreach (hot[i]) hot[i] = $urandom_range(0, rbpf_pkg::LEVEL_COUNT - 1);
          repeat (40) begin
            pick = $urandom_range(0, 99);
            lvl  = hot[$urandom_range(0, HOT_LEVELS - 1)];
            if (pick < 45) begin
              queue_event(rbpf_pkg::ACT_PUSH, (rbpf_pkg::PRIO_W)'(lvl), ph);
            end else if (pick < 85) begin
              queue_event(rbpf_pkg::ACT_REMOVE, (rbpf_pkg::PRIO_W)'(lvl), ph);
            end else begin
              queue_event(1'($urandom_range(0, 1)),
                          (rbpf_pkg::PRIO_W)'($urandom_range(0, 255)), ph);
            end
          end
        end
      end
    end
    total = pending_events.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (events_accepted < total || expected_levels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/rbpf_pkg.sv
rtl/core/rbpf_ram.sv
rtl/core/rbpf_front.sv
rtl/core/rbpf_back.sv
rtl/core/ready_bitmap_priority_finder.sv
sim/tb_top.sv
